@@ rtl/cicid_pkg.sv @@
package cicid_pkg;

   localparam int unsigned KeyCount = 4;
   localparam int unsigned CfgIndexWidth = 2;
   localparam int unsigned CfgDataWidth = 32;

   typedef logic [7:0] key_byte_type;
   typedef key_byte_type [KeyCount-1:0] key_table_type;

   // Key bytes, indexed by table position modulo four.
   localparam key_table_type KeyTable = '{
      8'hde, 8'ha5, 8'h8c, 8'hb6
   };

   typedef enum logic [CfgIndexWidth-1:0] {
      CFG_POINTER_BYTES     = 2'd0,
      CFG_DATA_START_OFFSET = 2'd1,
      CFG_ENTRY_COUNT       = 2'd2,
      CFG_UNUSED            = 2'd3
   } cfg_index_type;

   localparam logic [2:0] PointerBytesReset = 3'd4;

endpackage

@@ rtl/compressed_image_chunk_index_decoder_core.sv @@
// A result appears on the rsp_ outputs in the cycle after its last byte is accepted.
// Throughput: one byte per cycle while rsp_ready is high. The entry state is updated in a
// single pass per byte; while a result waits with rsp_ready low, no byte is taken.
// Reset (synchronous, active high) clears the table state and the output valid and sets
// the registers to pointer_bytes 4, data_start_offset 0, entry_count 0.
module compressed_image_chunk_index_decoder_core (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [7:0]                             req_table_byte,
   input  logic                                   req_table_start,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [1:0]                             rsp_chunk_kind,
   output logic [29:0]                            rsp_chunk_length,
   output logic [31:0]                            rsp_chunk_offset,
   output logic                                   rsp_final_entry,
   input  logic                                   csr_write_en,
   input  logic [cicid_pkg::CfgIndexWidth-1:0]    csr_index,
   input  logic [cicid_pkg::CfgDataWidth-1:0]     csr_wdata
);
   import cicid_pkg::*;

   logic [2:0]  pointer_bytes_ff;
   logic [31:0] data_start_offset_ff;
   logic [23:0] entry_count_ff;

   logic [1:0]  key_phase_ff, key_phase_in;
   logic [1:0]  byte_in_entry_ff, byte_in_entry_in;
   logic [23:0] partial_word_ff, partial_word_in;
   logic [31:0] next_offset_ff, next_offset_in;
   logic [23:0] entries_done_ff, entries_done_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  chunk_kind_ff, chunk_kind_in;
   logic [29:0] chunk_length_ff, chunk_length_in;
   logic [31:0] chunk_offset_ff, chunk_offset_in;
   logic        final_entry_ff, final_entry_in;

   logic        accept;
   logic [1:0]  cur_phase, cur_bie;
   logic [23:0] cur_partial, cur_done;
   logic [31:0] cur_next;
   logic [7:0]  clear_byte;
   logic [2:0]  plen;
   logic [31:0] word;
   logic [31:0] offset;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pointer_bytes_ff     <= PointerBytesReset;
         data_start_offset_ff <= '0;
         entry_count_ff       <= '0;
      end else if (csr_write_en) begin
         unique case (cfg_index_type'(csr_index))
            CFG_POINTER_BYTES:     pointer_bytes_ff     <= csr_wdata[2:0];
            CFG_DATA_START_OFFSET: data_start_offset_ff <= csr_wdata[31:0];
            CFG_ENTRY_COUNT:       entry_count_ff       <= csr_wdata[23:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      // A table start restarts the running state before its byte is used.
      cur_phase   = req_table_start ? 2'd0  : key_phase_ff;
      cur_bie     = req_table_start ? 2'd0  : byte_in_entry_ff;
      cur_partial = req_table_start ? 24'd0 : partial_word_ff;
      cur_next    = req_table_start ? 32'd0 : next_offset_ff;
      cur_done    = req_table_start ? 24'd0 : entries_done_ff;

      clear_byte = req_table_byte ^ KeyTable[cur_phase];

      if (pointer_bytes_ff == 3'd0) begin
         plen = 3'd1;
      end else if (pointer_bytes_ff > 3'd4) begin
         plen = 3'd4;
      end else begin
         plen = pointer_bytes_ff;
      end

      word = {8'd0, cur_partial} | ({24'd0, clear_byte} << {cur_bie, 3'b000});
      offset = (cur_done == 24'd0) ? data_start_offset_ff : cur_next;

      unique case (plen)
         3'd1: begin
            chunk_kind_in   = word[7:6];
            chunk_length_in = {24'd0, word[5:0]};
         end
         3'd2: begin
            chunk_kind_in   = word[15:14];
            chunk_length_in = {16'd0, word[13:0]};
         end
         3'd3: begin
            chunk_kind_in   = word[23:22];
            chunk_length_in = {8'd0, word[21:0]};
         end
         default: begin
            chunk_kind_in   = word[31:30];
            chunk_length_in = word[29:0];
         end
      endcase
      chunk_offset_in = offset;
      final_entry_in  = (cur_done + 24'd1) == entry_count_ff;

      key_phase_in     = key_phase_ff;
      byte_in_entry_in = byte_in_entry_ff;
      partial_word_in  = partial_word_ff;
      next_offset_in   = next_offset_ff;
      entries_done_in  = entries_done_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;

      if (accept) begin
         key_phase_in     = cur_phase + 2'd1;
         byte_in_entry_in = cur_bie;
         partial_word_in  = cur_partial;
         next_offset_in   = cur_next;
         entries_done_in  = cur_done;
         if (cur_done < entry_count_ff) begin
            if ({1'b0, cur_bie} + 3'd1 < plen) begin
               partial_word_in  = word[23:0];
               byte_in_entry_in = cur_bie + 2'd1;
            end else begin
               next_offset_in   = offset + {2'd0, chunk_length_in};
               entries_done_in  = cur_done + 24'd1;
               byte_in_entry_in = 2'd0;
               partial_word_in  = 24'd0;
               rsp_valid_in     = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_phase_ff     <= '0;
         byte_in_entry_ff <= '0;
         partial_word_ff  <= '0;
         next_offset_ff   <= '0;
         entries_done_ff  <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         key_phase_ff     <= key_phase_in;
         byte_in_entry_ff <= byte_in_entry_in;
         partial_word_ff  <= partial_word_in;
         next_offset_ff   <= next_offset_in;
         entries_done_ff  <= entries_done_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // The result register loads only when an entry completes.
   always_ff @(posedge clock) begin
      if (accept && rsp_valid_in) begin
         chunk_kind_ff   <= chunk_kind_in;
         chunk_length_ff <= chunk_length_in;
         chunk_offset_ff <= chunk_offset_in;
         final_entry_ff  <= final_entry_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_chunk_kind   = chunk_kind_ff;
   assign rsp_chunk_length = chunk_length_ff;
   assign rsp_chunk_offset = chunk_offset_ff;
   assign rsp_final_entry  = final_entry_ff;

`ifndef ASSERT_OFF
   a_reset_clears_valid: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff)
      else $error("result valid set after reset");

   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !req_ready)
      else $error("byte accepted while a result is stalled");

   a_empty_entry_clear: assert property (@(posedge clock) disable iff (reset)
      (byte_in_entry_ff == 2'd0) |-> (partial_word_ff == 24'd0))
      else $error("partial entry bits left at entry boundary");

   a_result_from_byte: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(req_valid && req_ready))
      else $error("result appeared without an accepted byte");
`endif

endmodule

@@ tb/sv/chunk_entry_checker.sv @@
`timescale 1ns / 100ps

module chunk_entry_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic [7:0]                          req_table_byte,
   input  logic                                req_table_start,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic [1:0]                          rsp_chunk_kind,
   input  logic [29:0]                         rsp_chunk_length,
   input  logic [31:0]                         rsp_chunk_offset,
   input  logic                                rsp_final_entry,
   input  logic                                csr_write_en,
   input  logic [cicid_pkg::CfgIndexWidth-1:0] csr_index,
   input  logic [cicid_pkg::CfgDataWidth-1:0]  csr_wdata,
   output int unsigned                         failures,
   output int unsigned                         outstanding
);
   import cicid_pkg::*;

   typedef struct packed {
      logic [1:0]  kind;
      logic [29:0] length;
      logic [31:0] offset;
      logic        last_entry;
   } chunk_entry_type;

   // Shadow copy of the registers and the running table state.
   logic [2:0]  pointer_bytes;
   logic [31:0] data_start;
   logic [23:0] entry_limit;
   logic [1:0]  key_phase;
   logic [1:0]  byte_in_entry;
   logic [23:0] partial_word;
   logic [31:0] next_offset;
   logic [23:0] entries_done;

   chunk_entry_type expected_entries[$];
   chunk_entry_type decoded;
   chunk_entry_type want;
   chunk_entry_type got;
   bit              produced;

   initial begin
      failures = 0;
      outstanding = 0;
   end

   task automatic restart_table();
      key_phase = '0;
      byte_in_entry = '0;
      partial_word = '0;
      next_offset = '0;
      entries_done = '0;
   endtask

   // Takes one obfuscated byte and tells whether it completes a chunk entry.
   task automatic decode_table_byte(input logic [7:0] raw, input logic start,
                                    output bit done, output chunk_entry_type entry);
      logic [7:0]  clear;
      logic [2:0]  plen;
      logic [31:0] word;
      logic [31:0] length;
      int          len_bits;
      done = 1'b0;
      entry = '0;
      if (start) begin
         restart_table();
      end
      clear = raw ^ KeyTable[key_phase];
      key_phase = key_phase + 2'd1;
      if (entries_done < entry_limit) begin
         plen = (pointer_bytes == 3'd0) ? 3'd1 : (pointer_bytes > 3'd4) ? 3'd4 : pointer_bytes;
         word = {8'h00, partial_word} | ({24'h0, clear} << (8 * byte_in_entry));
         if (byte_in_entry + 1 < plen) begin
            partial_word = word[23:0];
            byte_in_entry = byte_in_entry + 2'd1;
         end else begin
            len_bits = plen * 8 - 2;
            length = word & ((32'd1 << len_bits) - 32'd1);
            entry.kind = 2'((word >> len_bits) & 32'd3);
            entry.length = length[29:0];
            // The first entry of a table always starts at the programmed data offset.
            entry.offset = (entries_done == 24'd0) ? data_start : next_offset;
            entry.last_entry = ({1'b0, entries_done} + 25'd1) == {1'b0, entry_limit};
            next_offset = entry.offset + length;
            entries_done = entries_done + 24'd1;
            byte_in_entry = '0;
            partial_word = '0;
            done = 1'b1;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         pointer_bytes = PointerBytesReset;
         data_start = '0;
         entry_limit = '0;
         restart_table();
         expected_entries.delete();
      end else begin
         if (csr_write_en) begin
            case (cfg_index_type'(csr_index))
               CFG_POINTER_BYTES:     pointer_bytes = csr_wdata[2:0];
               CFG_DATA_START_OFFSET: data_start = csr_wdata;
               CFG_ENTRY_COUNT:       entry_limit = csr_wdata[23:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            decode_table_byte(req_table_byte, req_table_start, produced, decoded);
            if (produced) begin
               expected_entries.push_back(decoded);
            end
         end
         if (rsp_valid && rsp_ready) begin
            got.kind = rsp_chunk_kind;
            got.length = rsp_chunk_length;
            got.offset = rsp_chunk_offset;
            got.last_entry = rsp_final_entry;
            if (expected_entries.size() == 0) begin
               $display("%0t: unexpected chunk entry: kind %0d length %h offset %h final %0b",
                        $time, got.kind, got.length, got.offset, got.last_entry);
               failures <= failures + 1;
            end else begin
               want = expected_entries.pop_front();
               if (got !== want) begin
                  $display("%0t: chunk entry mismatch: expected kind %0d length %h offset %h final %0b",
                           $time, want.kind, want.length, want.offset, want.last_entry);
                  $display("%0t:                       actual   kind %0d length %h offset %h final %0b",
                           $time, got.kind, got.length, got.offset, got.last_entry);
                  failures <= failures + 1;
               end
            end
         end
      end
      outstanding <= expected_entries.size();
   end

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
   import cicid_pkg::*;

   localparam int unsigned StallLimit = 5000;
   localparam int unsigned RandomItems = 1650;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_table_byte = '0;
   logic        req_table_start = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_chunk_kind;
   logic [29:0] rsp_chunk_length;
   logic [31:0] rsp_chunk_offset;
   logic        rsp_final_entry;
   logic        csr_write_en = 1'b0;
   logic [CfgIndexWidth-1:0] csr_index = '0;
   logic [CfgDataWidth-1:0]  csr_wdata = '0;

   int unsigned failures;
   int unsigned pending;
   int unsigned idle_cycles = 0;
   int unsigned ready_stall = 0;
   int unsigned items_sent = 0;
   bit          quiet = 1'b0;
   logic [1:0]  key_pos = '0;

   always #4 clock = ~clock;

   compressed_image_chunk_index_decoder_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_table_byte   (req_table_byte),
      .req_table_start  (req_table_start),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_chunk_kind   (rsp_chunk_kind),
      .rsp_chunk_length (rsp_chunk_length),
      .rsp_chunk_offset (rsp_chunk_offset),
      .rsp_final_entry  (rsp_final_entry),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   chunk_entry_checker entry_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_table_byte   (req_table_byte),
      .req_table_start  (req_table_start),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_chunk_kind   (rsp_chunk_kind),
      .rsp_chunk_length (rsp_chunk_length),
      .rsp_chunk_offset (rsp_chunk_offset),
      .rsp_final_entry  (rsp_final_entry),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .failures         (failures),
      .outstanding      (pending)
   );

   // Mostly short gaps, now and then a long one.
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      else if (r < 85) return $urandom_range(1, 3);
      else if (r < 97) return $urandom_range(4, 12);
      else return $urandom_range(20, 60);
   endfunction

   always @(posedge clock) begin
      if (ready_stall > 0) begin
         ready_stall <= ready_stall - 1;
         rsp_ready <= 1'b0;
      end else if (quiet || $urandom_range(0, 3) != 0) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= 1'b0;
         ready_stall <= pick_gap();
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= StallLimit) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   // Sends one table byte given in clear; the key is applied by table position.
   task automatic send_item(input logic [7:0] clear, input logic start);
      int unsigned gap;
      gap = quiet ? 0 : pick_gap();
      if (start) key_pos = '0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_table_byte <= clear ^ KeyTable[key_pos];
      req_table_start <= start;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      key_pos = key_pos + 2'd1;
      items_sent++;
   endtask

   task automatic send_entry(input logic [1:0] kind, input logic [31:0] length,
                             input int plen, input logic start);
      logic [31:0] word;
      int          i;
      word = (32'(kind) << (8 * plen - 2)) | (length & ((32'd1 << (8 * plen - 2)) - 32'd1));
      for (i = 0; i < plen; i++) begin
         send_item(word[8 * i +: 8], start && (i == 0));
      end
   endtask

   // Stops the sender until every expected entry has come back.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic set_table(input logic [2:0] pb, input logic [31:0] base,
                            input logic [23:0] count);
      logic [31:0] junk;
      junk = $urandom;
      csr_write_en <= 1'b1;
      csr_index <= CFG_POINTER_BYTES;
      csr_wdata <= {junk[31:3], pb};
      @(posedge clock);
      csr_index <= CFG_DATA_START_OFFSET;
      csr_wdata <= base;
      @(posedge clock);
      csr_index <= CFG_ENTRY_COUNT;
      csr_wdata <= {junk[7:0], count};
      @(posedge clock);
      csr_index <= CFG_UNUSED;
      csr_wdata <= $urandom;
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   initial begin
      logic [2:0]  pb;
      logic [31:0] base;
      logic [23:0] count;
      int          plen;
      int          n;
      int          e;
      bit          with_start;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Bytes before any table start, with no entries programmed.
      send_item(8'h00, 1'b0);
      send_item(8'hff, 1'b0);
      // Continue the implicit table; the offsets wrap past the top of the range.
      drain();
      set_table(3'd4, 32'hffff_fff0, 24'd3);
      send_entry(2'd3, 32'h3fff_ffff, 4, 1'b0);
      send_entry(2'd0, 32'h0, 4, 1'b0);
      send_entry(2'd2, 32'd5, 4, 1'b1);
      // One-byte entries, the final flag and a byte past the entry count.
      drain();
      set_table(3'd1, 32'h0000_1000, 24'd2);
      send_entry(2'd1, 32'h3f, 1, 1'b1);
      send_entry(2'd2, 32'h0, 1, 1'b0);
      send_item(8'h5a, 1'b0);
      // Pointer length zero behaves as one.
      drain();
      set_table(3'd0, 32'h0, 24'hffffff);
      send_entry(2'd0, 32'd1, 1, 1'b1);
      // Pointer length seven behaves as four; then the length shrinks mid-entry.
      drain();
      set_table(3'd7, 32'h8000_0000, 24'hffffff);
      send_item(8'h81, 1'b1);
      drain();
      set_table(3'd3, 32'h7fff_ffff, 24'hffffff);
      send_item(8'hc3, 1'b0);
      send_item(8'h3c, 1'b0);
      drain();
      set_table(3'd2, 32'h1234_5678, 24'hffffff);
      send_item(8'he7, 1'b0);
      drain();
      set_table(3'd1, 32'h1234_5678, 24'hffffff);
      send_item(8'h18, 1'b0);
      send_entry(2'd1, 32'h2abc, 1, 1'b0);

      items_sent = 0;
      while (items_sent < RandomItems) begin
         quiet = ($urandom_range(0, 4) == 0);
         if ($urandom_range(0, 9) == 0) begin
            pb = 3'($urandom_range(4, 7));
            if (pb == 3'd4) pb = 3'd0;
         end else begin
            pb = 3'($urandom_range(1, 4));
         end
         case ($urandom_range(0, 5))
            0: base = 32'h0;
            1: base = 32'hffff_ffff;
            default: base = $urandom;
         endcase
         case ($urandom_range(0, 19))
            0: count = 24'd0;
            1: count = 24'hffffff;
            2: count = 24'($urandom_range(13, 40));
            default: count = 24'($urandom_range(1, 12));
         endcase
         plen = (pb == 3'd0) ? 1 : (pb > 3'd4) ? 4 : int'(pb);
         drain();
         set_table(pb, base, count);
         if ($urandom_range(0, 6) == 0) begin
            // Noise: loose bytes with an occasional table start anywhere.
            n = $urandom_range(1, 24);
            for (e = 0; e < n; e++) begin
               send_item(8'($urandom), $urandom_range(0, 9) == 0);
            end
         end else begin
            n = (count == 24'd0 || count > 24'd40) ? $urandom_range(1, 30) : int'(count);
            with_start = ($urandom_range(0, 9) != 0);
            for (e = 0; e < n; e++) begin
               send_entry(2'($urandom_range(0, 3)),
                          ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : $urandom,
                          plen, with_start && (e == 0));
            end
            // Trailing bytes run past the entry count or leave an entry half done.
            if ($urandom_range(0, 3) == 0) begin
               n = $urandom_range(1, 5);
               for (e = 0; e < n; e++) begin
                  send_item(8'($urandom), 1'b0);
               end
            end
         end
      end

      drain();
      repeat (4) @(posedge clock);
      if (failures == 0 && pending == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
